// ----- rtl/hba_pkg.sv -----
// Shared types and constants of the heap block allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package hba_pkg;

  // Fixed field widths of the ports
  localparam int REQ_W      = 24;
  localparam int OUT_ADDR_W = 24;
  localparam int LIMIT_W    = 24;
  localparam int FIT_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_BLOCKS   = 16;
  localparam int DEF_HEADER_BYTES = 32;
  localparam int DEF_ADDR_BITS    = 24;

  // Alignment granule of a request
  localparam int ALIGN_BYTES = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd1;

  // Fit modes
  localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;
  localparam logic [FIT_W-1:0] FIT_NEXT  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOM     = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd3;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Selection policy of the candidate chain
  typedef enum logic [2:0] {
    POL_FIRST,
    POL_BEST,
    POL_WORST,
    POL_NEXT,
    POL_FREE
  } pol_t;

  // Table update broadcast to all cells
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_TAKE,
    OP_MARK,
    OP_GROW,
    OP_SPLIT,
    OP_MERGE
  } upd_op_t;

  typedef struct packed {
    pol_t    pol;
    upd_op_t op;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/hba_cell.sv -----
// One table entry of the heap block allocator plus its stage of the
// candidate chain. Depends on hba_pkg.
`default_nettype none

module hba_cell import hba_pkg::*; #(
  parameter int ADDR_BITS    = DEF_ADDR_BITS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5,
  parameter int CELL_IDX     = 0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  cell_ctl_t            ctl,
  input  wire [IDX_W-1:0]      op_idx,
  input  wire [IDX_W-1:0]      scan_start,
  input  wire [CNT_W-1:0]      count,
  input  wire [REQ_W:0]        need,
  input  wire [REQ_W-1:0]      free_addr,
  input  wire [ADDR_BITS-1:0]  wr_start,
  input  wire [ADDR_BITS-1:0]  left_start,
  input  wire [ADDR_BITS-1:0]  left_size,
  input  wire [ADDR_BITS-1:0]  right_start,
  input  wire [ADDR_BITS-1:0]  right_size,
  input  wire                  right_free,
  input  wire                  shift_free,
  input  wire                  cand_in_found,
  input  wire [IDX_W-1:0]      cand_in_idx,
  input  wire [ADDR_BITS-1:0]  cand_in_start,
  input  wire [ADDR_BITS-1:0]  cand_in_size,
  output logic [ADDR_BITS-1:0] start,
  output logic [ADDR_BITS-1:0] size,
  output logic                 free,
  output logic                 cand_out_found,
  output logic [IDX_W-1:0]     cand_out_idx,
  output logic [ADDR_BITS-1:0] cand_out_start,
  output logic [ADDR_BITS-1:0] cand_out_size
);

  localparam int CMP_W = ((ADDR_BITS > REQ_W + 1) ? ADDR_BITS : REQ_W + 1) + 3;
  localparam logic [CMP_W-1:0] HDR = CMP_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MY  = CNT_W'(CELL_IDX);

  logic [ADDR_BITS-1:0] start_r, start_nxt;
  logic [ADDR_BITS-1:0] size_r, size_nxt;
  logic                 free_r, free_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     cidx_r, cidx_nxt;
  logic [ADDR_BITS-1:0] cstart_r, cstart_nxt;
  logic [ADDR_BITS-1:0] csize_r, csize_nxt;

  logic             valid;
  logic             fit;
  logic             hit;
  logic             elig;
  logic             take;
  logic             in_high;
  logic             me_high;
  logic [CNT_W-1:0] idx_e;
  logic [CMP_W-1:0] split_start;
  logic [CMP_W-1:0] split_size;
  logic [CMP_W-1:0] merge_size;

  assign valid   = MY < count;
  assign fit     = valid && free_r && (CMP_W'(size_r) >= CMP_W'(need));
  assign hit     = valid && !free_r && ((CMP_W'(start_r) + HDR) == CMP_W'(free_addr));
  assign elig    = (ctl.pol == POL_FREE) ? hit : fit;
  assign in_high = cand_in_idx >= scan_start;
  assign me_high = IDX_W'(CELL_IDX) >= scan_start;

  // Decide whether this entry replaces the candidate from the left
  always_comb begin
    case (ctl.pol)
      POL_BEST:  take = elig && (!cand_in_found || (size_r < cand_in_size));
      POL_WORST: take = elig && (!cand_in_found || (size_r > cand_in_size));
      POL_NEXT:  take = elig && (!cand_in_found || (!in_high && me_high));
      default:   take = elig && !cand_in_found;
    endcase
  end

  // Advance the candidate chain
  always_comb begin
    if (take) begin
      found_nxt  = 1'b1;
      cidx_nxt   = IDX_W'(CELL_IDX);
      cstart_nxt = start_r;
      csize_nxt  = size_r;
    end else begin
      found_nxt  = cand_in_found;
      cidx_nxt   = cand_in_idx;
      cstart_nxt = cand_in_start;
      csize_nxt  = cand_in_size;
    end
  end

  assign idx_e       = CNT_W'(op_idx);
  assign split_start = CMP_W'(left_start) + HDR + CMP_W'(need);
  assign split_size  = CMP_W'(left_size) - CMP_W'(need) - HDR;
  assign merge_size  = CMP_W'(size_r) + HDR + CMP_W'(right_size);

  // Apply the broadcast table update
  always_comb begin
    start_nxt = start_r;
    size_nxt  = size_r;
    free_nxt  = free_r;
    case (ctl.op)
      OP_TAKE: begin
        if (MY == idx_e) free_nxt = 1'b0;
      end
      OP_MARK: begin
        if (MY == idx_e) free_nxt = 1'b1;
      end
      OP_GROW: begin
        if (MY == idx_e) begin
          start_nxt = wr_start;
          size_nxt  = ADDR_BITS'(need);
          free_nxt  = 1'b0;
        end
      end
      OP_SPLIT: begin
        if (MY == idx_e) begin
          size_nxt = ADDR_BITS'(need);
          free_nxt = 1'b0;
        end else if (MY == idx_e + CNT_W'(1)) begin
          start_nxt = split_start[ADDR_BITS-1:0];
          size_nxt  = split_size[ADDR_BITS-1:0];
          free_nxt  = 1'b1;
        end else if (MY > idx_e + CNT_W'(1)) begin
          start_nxt = left_start;
          size_nxt  = left_size;
          free_nxt  = shift_free;
        end
      end
      OP_MERGE: begin
        if (MY == idx_e) begin
          size_nxt = merge_size[ADDR_BITS-1:0];
        end else if (MY > idx_e) begin
          start_nxt = right_start;
          size_nxt  = right_size;
          free_nxt  = right_free;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      size_r  <= '0;
      free_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      start_r <= start_nxt;
      size_r  <= size_nxt;
      free_r  <= free_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cidx_r   <= cidx_nxt;
    cstart_r <= cstart_nxt;
    csize_r  <= csize_nxt;
  end

  assign start          = start_r;
  assign size           = size_r;
  assign free           = free_r;
  assign cand_out_found = found_r;
  assign cand_out_idx   = cidx_r;
  assign cand_out_start = cstart_r;
  assign cand_out_size  = csize_r;

endmodule

`default_nettype wire

// ----- rtl/hba_free_link.sv -----
// Free-mark hand-off between neighboring cells during a split shift.
// Depends on hba_pkg; used by the top level for each cell position.
`default_nettype none

module hba_free_link import hba_pkg::*; #(
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  cell_ctl_t        ctl,
  input  wire [IDX_W-1:0]  op_idx,
  input  wire              left_free,
  input  wire              own_free,
  output logic             free_out
);

  localparam logic [CNT_W-1:0] MY = CNT_W'(CELL_IDX);

  logic shift;

  // This cell takes its left neighbor's entry in a split
  assign shift = (ctl.op == OP_SPLIT) && (MY > CNT_W'(op_idx) + CNT_W'(1));

  // Free mark the cell loads
  assign free_out = shift ? left_free : own_free;

endmodule

`default_nettype wire

// ----- rtl/heap_block_allocator.sv -----
// Heap block allocator: a row of table cells with a registered candidate
// chain, sequenced by a control FSM. Depends on hba_pkg, hba_cell and hba_free_link.
//
// Usage:
//   Input channel in_valid/in_stall carries one transaction: in_kind
//   (0 allocate, 1 free), in_request_size and in_block_address. The result
//   channel out_valid/out_stall returns out_status and out_address, one
//   result per input transaction, in order.
//   Configuration: cfg_we with cfg_index 0 writes fit_mode, index 1 writes
//   heap_limit; write only while the block is idle.
//   From the accepting edge to out_valid the candidate walks the chain of
//   cells in S_SCAN, then S_DECIDE decides, then for a free that finds its
//   block the merge states S_MERGE_P and S_MERGE_N run, then S_DONE loads
//   the output register. One transaction is in flight at a time; the next
//   is accepted once the block is back in S_IDLE after the result is loaded.
//   Reset (rst_n low, synchronous) empties the table, zeroes heap top and
//   rover and restores fit_mode 0 and heap_limit 65536.
//   While out_stall is high the finished result is held in the output
//   register, and a later result waits in S_DONE until out_stall is low.
`default_nettype none

module heap_block_allocator import hba_pkg::*; #(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   in_kind,
  input  wire [REQ_W-1:0]       in_request_size,
  input  wire [REQ_W-1:0]       in_block_address,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic [OUT_ADDR_W-1:0] out_address
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = ((ADDR_BITS > REQ_W + 1) ? ADDR_BITS : REQ_W + 1) + 3;
  localparam logic [CMP_W-1:0] HDR = CMP_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BLOCKS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_BLOCKS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MERGE_P,
    S_MERGE_N,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [FIT_W-1:0]      fit_r, fit_nxt;
  logic [LIMIT_W-1:0]    limit_r, limit_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ADDR_BITS-1:0]  top_r, top_nxt;
  logic [IDX_W-1:0]      rover_r, rover_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [IDX_W-1:0]      scan_r, scan_nxt;
  logic [IDX_W-1:0]      sstart_r, sstart_nxt;
  pol_t                  pol_r, pol_nxt;
  logic                  kind_r, kind_nxt;
  logic [REQ_W-1:0]      req_r, req_nxt;
  logic [REQ_W:0]        need_r, need_nxt;
  logic [REQ_W-1:0]      faddr_r, faddr_nxt;
  logic [STAT_W-1:0]     rstat_r, rstat_nxt;
  logic [OUT_ADDR_W-1:0] raddr_r, raddr_nxt;
  logic                  ov_r, ov_nxt;
  logic [STAT_W-1:0]     ostat_r, ostat_nxt;
  logic [OUT_ADDR_W-1:0] oaddr_r, oaddr_nxt;

  cell_ctl_t             ctl;
  logic [IDX_W-1:0]      op_idx;

  logic [ADDR_BITS-1:0]  c_start [MAX_BLOCKS];
  logic [ADDR_BITS-1:0]  c_size  [MAX_BLOCKS];
  logic                  c_free  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] free_vec;
  logic                  k_found [MAX_BLOCKS];
  logic [IDX_W-1:0]      k_idx   [MAX_BLOCKS];
  logic [ADDR_BITS-1:0]  k_start [MAX_BLOCKS];
  logic [ADDR_BITS-1:0]  k_size  [MAX_BLOCKS];

  logic [REQ_W:0]        need_in;
  logic [CMP_W-1:0]      grow_top;
  logic [CMP_W-1:0]      hit_addr;
  logic [CMP_W-1:0]      grow_addr;
  logic                  do_split;
  logic [IDX_W-1:0]      f_idx;
  logic [IDX_W-1:0]      cur_dn;
  logic [IDX_W-1:0]      cur_up;

  // Row of table cells; each hands its candidate to the right every cycle
  genvar gi;
  generate
    for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
      logic [ADDR_BITS-1:0] ls, lz, rs, rz;
      logic                 rf, cf;
      logic                 lf, sf;
      logic                 kf;
      logic [IDX_W-1:0]     ki;
      logic [ADDR_BITS-1:0] kst, ksz;
      if (gi == 0) begin : g_first
        assign ls  = '0;
        assign lz  = '0;
        assign lf  = 1'b0;
        assign kf  = 1'b0;
        assign ki  = '0;
        assign kst = '0;
        assign ksz = '0;
      end else begin : g_mid
        assign ls  = c_start[gi-1];
        assign lz  = c_size[gi-1];
        assign lf  = c_free[gi-1];
        assign kf  = k_found[gi-1];
        assign ki  = k_idx[gi-1];
        assign kst = k_start[gi-1];
        assign ksz = k_size[gi-1];
      end
      if (gi == MAX_BLOCKS - 1) begin : g_last
        assign rs = '0;
        assign rz = '0;
        assign rf = 1'b0;
      end else begin : g_inner
        assign rs = c_start[gi+1];
        assign rz = c_size[gi+1];
        assign rf = c_free[gi+1];
      end
      hba_free_link #(
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W),
        .CELL_IDX (gi)
      ) u_link (
        .ctl       (ctl),
        .op_idx    (op_idx),
        .left_free (lf),
        .own_free  (cf),
        .free_out  (sf)
      );
      hba_cell #(
        .ADDR_BITS    (ADDR_BITS),
        .HEADER_BYTES (HEADER_BYTES),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W),
        .CELL_IDX     (gi)
      ) u_cell (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .op_idx         (op_idx),
        .scan_start     (sstart_r),
        .count          (count_r),
        .need           (need_r),
        .free_addr      (faddr_r),
        .wr_start       (top_r),
        .left_start     (ls),
        .left_size      (lz),
        .right_start    (rs),
        .right_size     (rz),
        .right_free     (rf),
        .shift_free     (sf),
        .cand_in_found  (kf),
        .cand_in_idx    (ki),
        .cand_in_start  (kst),
        .cand_in_size   (ksz),
        .start          (c_start[gi]),
        .size           (c_size[gi]),
        .free           (cf),
        .cand_out_found (k_found[gi]),
        .cand_out_idx   (k_idx[gi]),
        .cand_out_start (k_start[gi]),
        .cand_out_size  (k_size[gi])
      );
      assign c_free[gi]   = cf;
      assign free_vec[gi] = cf;
    end
  endgenerate

  // Round the request up to the alignment granule
  assign need_in   = ({1'b0, in_request_size} + (REQ_W+1)'(ALIGN_BYTES - 1)) &
                     ~(REQ_W+1)'(ALIGN_BYTES - 1);
  assign grow_top  = CMP_W'(top_r) + HDR + CMP_W'(need_r);
  assign hit_addr  = CMP_W'(k_start[MAX_BLOCKS-1]) + HDR;
  assign grow_addr = CMP_W'(top_r) + HDR;
  assign do_split  = (CMP_W'(k_size[MAX_BLOCKS-1]) >
                      CMP_W'(need_r) + HDR + CMP_W'(ALIGN_BYTES)) && (count_r < MAXC);
  assign f_idx     = k_idx[MAX_BLOCKS-1];
  assign cur_dn    = cur_r - IDX_W'(1);
  assign cur_up    = cur_r + IDX_W'(1);

  // Sequence one transaction at a time
  always_comb begin
    state_nxt  = state_r;
    fit_nxt    = fit_r;
    limit_nxt  = limit_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    rover_nxt  = rover_r;
    cur_nxt    = cur_r;
    scan_nxt   = scan_r;
    sstart_nxt = sstart_r;
    pol_nxt    = pol_r;
    kind_nxt   = kind_r;
    req_nxt    = req_r;
    need_nxt   = need_r;
    faddr_nxt  = faddr_r;
    rstat_nxt  = rstat_r;
    raddr_nxt  = raddr_r;
    ov_nxt     = ov_r && out_stall;
    ostat_nxt  = ostat_r;
    oaddr_nxt  = oaddr_r;
    ctl.pol    = pol_r;
    ctl.op     = OP_HOLD;
    op_idx     = cur_r;

    // Take configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_MODE:   fit_nxt = cfg_data[FIT_W-1:0];
        CFG_HEAP_LIMIT: limit_nxt = cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_kind;
          req_nxt    = in_request_size;
          need_nxt   = need_in;
          faddr_nxt  = in_block_address;
          scan_nxt   = '0;
          sstart_nxt = (CNT_W'(rover_r) < count_r) ? rover_r : '0;
          if (in_kind == KIND_FREE) begin
            pol_nxt = POL_FREE;
          end else begin
            case (fit_r)
              FIT_BEST:  pol_nxt = POL_BEST;
              FIT_WORST: pol_nxt = POL_WORST;
              FIT_NEXT:  pol_nxt = POL_NEXT;
              default:   pol_nxt = POL_FIRST;
            endcase
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r + IDX_W'(1);
        if (scan_r == LAST) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        rstat_nxt = ST_OK;
        raddr_nxt = '0;
        state_nxt = S_DONE;
        if (kind_r == KIND_ALLOC) begin
          if (req_r == '0) begin
            rstat_nxt = ST_ZERO;
          end else if (k_found[MAX_BLOCKS-1]) begin
            op_idx    = f_idx;
            raddr_nxt = hit_addr[OUT_ADDR_W-1:0];
            if (pol_r == POL_NEXT) rover_nxt = f_idx;
            if (do_split) begin
              ctl.op    = OP_SPLIT;
              count_nxt = count_r + CNT_W'(1);
              if (pol_r != POL_NEXT && rover_r > f_idx) rover_nxt = rover_r + IDX_W'(1);
            end else begin
              ctl.op = OP_TAKE;
            end
          end else if (count_r >= MAXC || grow_top > CMP_W'(limit_r)) begin
            rstat_nxt = ST_OOM;
          end else begin
            ctl.op    = OP_GROW;
            op_idx    = count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
            top_nxt   = grow_top[ADDR_BITS-1:0];
            raddr_nxt = grow_addr[OUT_ADDR_W-1:0];
          end
        end else if (faddr_r != '0) begin
          if (k_found[MAX_BLOCKS-1]) begin
            ctl.op    = OP_MARK;
            op_idx    = f_idx;
            cur_nxt   = f_idx;
            state_nxt = S_MERGE_P;
          end else begin
            rstat_nxt = ST_BADFREE;
          end
        end
      end
      S_MERGE_P: begin
        // Absorb the freed block into a free block before it
        if (cur_r != '0 && free_vec[cur_dn]) begin
          ctl.op    = OP_MERGE;
          op_idx    = cur_dn;
          cur_nxt   = cur_dn;
          count_nxt = count_r - CNT_W'(1);
          if (rover_r >= cur_r && rover_r != '0) rover_nxt = rover_r - IDX_W'(1);
        end
        state_nxt = S_MERGE_N;
      end
      S_MERGE_N: begin
        // Absorb a free block after it
        if ((CNT_W'(cur_r) + CNT_W'(1) < count_r) && free_vec[cur_up]) begin
          ctl.op    = OP_MERGE;
          op_idx    = cur_r;
          count_nxt = count_r - CNT_W'(1);
          if (rover_r >= cur_up && rover_r != '0) rover_nxt = rover_r - IDX_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ostat_nxt = rstat_r;
          oaddr_nxt = raddr_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fit_r   <= FIT_FIRST;
      limit_r <= LIMIT_W'(65536);
      count_r <= '0;
      top_r   <= '0;
      rover_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fit_r   <= fit_nxt;
      limit_r <= limit_nxt;
      count_r <= count_nxt;
      top_r   <= top_nxt;
      rover_r <= rover_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Hold transaction payload and results
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    scan_r   <= scan_nxt;
    sstart_r <= sstart_nxt;
    pol_r    <= pol_nxt;
    kind_r   <= kind_nxt;
    req_r    <= req_nxt;
    need_r   <= need_nxt;
    faddr_r  <= faddr_nxt;
    rstat_r  <= rstat_nxt;
    raddr_r  <= raddr_nxt;
    ostat_r  <= ostat_nxt;
    oaddr_r  <= oaddr_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = ov_r;
  assign out_status  = ostat_r;
  assign out_address = oaddr_r;

  // Table never holds more entries than cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXC)
    else $error("entry count beyond table size");

  // Rover never points past the table contents
  a_rover_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(rover_r) <= count_r)
    else $error("rover past entry count");

  // Only one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while busy");

  // A merge only shrinks a table that holds at least two entries
  a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_MERGE) |-> (count_r >= CNT_W'(2)))
    else $error("merge on a table with fewer than two entries");

endmodule

`default_nettype wire
